/* hw/rtl/gcd_pkg.sv */
// Package with the constants, tables and helper functions of the great-circle distance block.
package gcd_pkg;

  localparam int unsigned CORDIC_STAGES   = 24;
  localparam int unsigned ANGLE_FRAC_BITS = 16;

  localparam int unsigned WB    = 30;
  localparam int unsigned CW    = 34;
  localparam int unsigned DEG_W = 26;
  localparam int unsigned MAG_W = 23;
  localparam int unsigned SC_W  = ANGLE_FRAC_BITS + 2;
  localparam int unsigned ANG_W = ANGLE_FRAC_BITS + 2;
  localparam int unsigned SQ_W  = ANGLE_FRAC_BITS + 1;
  localparam int unsigned RM_W  = 2 * SQ_W;
  localparam int unsigned OUT_W = 22;

  localparam logic signed [DEG_W-1:0] DEG_FULL  = 26'sd23592960;
  localparam logic signed [DEG_W-1:0] DEG_HALF  = 26'sd11796480;
  localparam logic signed [DEG_W-1:0] DEG_QUART = 26'sd5898240;

  localparam logic [33:0] PI_Q32     = 34'd13493037705;
  localparam int unsigned RAD_SHIFT  = 48 - ANGLE_FRAC_BITS;
  localparam int unsigned RAD_P_W    = MAG_W + 34;
  localparam logic [RAD_P_W-1:0] RAD_HALF_DEN = RAD_P_W'(90) << RAD_SHIFT;
  localparam int unsigned RAD_T_W    = ANGLE_FRAC_BITS + 9;
  localparam int unsigned RCP_K      = RAD_T_W + 8;
  localparam int unsigned RCP_W      = RCP_K - 7;
  localparam longint unsigned RCP_VAL = ((64'd1 << RCP_K) + 64'd179) / 64'd180;
  localparam logic [RCP_W-1:0] RCP_M = RCP_W'(RCP_VAL);
  localparam int unsigned Q_W        = ANGLE_FRAC_BITS + 1;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] PI_Q30   = 34'sd3373259426;

  localparam logic [11:0] MILES_PER_RAD = 12'd3963;
  localparam logic [23:0] NM_FACTOR_Q24 = 24'd14578998;
  localparam logic [OUT_W-1:0] OUT_MAX  = {OUT_W{1'b1}};

  localparam int unsigned SC_LAT   = CORDIC_STAGES + 5;
  localparam int unsigned ACOS_LAT = CORDIC_STAGES + SQ_W + 4;

  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      24: v = 30'd64;
      25: v = 30'd32;
      26: v = 30'd16;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Rounds half away from zero while dropping s fraction bits, s at least one.
  function automatic logic signed [63:0] rnd_s(input logic signed [63:0] v,
                                               input int unsigned s);
    logic [63:0] m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -$signed(m) : $signed(m);
  endfunction

endpackage

/* hw/rtl/gcd_in_if.sv */
// Input channel carrying one pair of positions per item.
interface gcd_in_if;
  import gcd_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [23:0] lat_a_deg;
  logic signed [24:0] lon_a_deg;
  logic signed [23:0] lat_b_deg;
  logic signed [24:0] lon_b_deg;

  modport source (output valid, lat_a_deg, lon_a_deg, lat_b_deg, lon_b_deg, input ready);
  modport sink (input valid, lat_a_deg, lon_a_deg, lat_b_deg, lon_b_deg, output ready);
endinterface

/* hw/rtl/gcd_out_if.sv */
// Output channel carrying one pair of distances per item.
interface gcd_out_if;
  import gcd_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] dist_statute;
  logic [OUT_W-1:0] dist_nautical;

  modport source (output valid, dist_statute, dist_nautical, input ready);
  modport sink (input valid, dist_statute, dist_nautical, output ready);
endinterface

/* hw/rtl/great_circle_distance.sv */
// Great-circle distance by the spherical law of cosines, fully pipelined.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits; the data registers are not reset.
module great_circle_distance import gcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  gcd_in_if.sink     req_i,
  gcd_out_if.source  rsp_o
);

  logic en;
  logic out_vld_q;

  assign en        = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  logic               in_vld_q;
  logic signed [23:0] lat_a_q, lat_b_q;
  logic signed [24:0] lon_a_q, lon_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_a_q <= req_i.lat_a_deg;
      lat_b_q <= req_i.lat_b_deg;
      lon_a_q <= req_i.lon_a_deg;
      lon_b_q <= req_i.lon_b_deg;
    end
  end

  logic signed [DEG_W-1:0] dl_d, dl_q, la_q, lb_q;
  logic                    red_vld_q;

  always_comb begin
    dl_d = DEG_W'(lon_b_q) - DEG_W'(lon_a_q);
    if (dl_d >= DEG_HALF) begin
      dl_d = dl_d - DEG_FULL;
    end else if (dl_d < -DEG_HALF) begin
      dl_d = dl_d + DEG_FULL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q <= dl_d;
      la_q <= DEG_W'(lat_a_q);
      lb_q <= DEG_W'(lat_b_q);
    end
  end

  logic                   sc_vld;
  logic                   sc_vld_b, sc_vld_d;
  logic signed [SC_W-1:0] sa, ca, sb, cb, sd, cd;

  gcd_sincos u_sc_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(red_vld_q), .deg_i(la_q),
    .valid_o(sc_vld), .sin_o(sa), .cos_o(ca)
  );
  gcd_sincos u_sc_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(red_vld_q), .deg_i(lb_q),
    .valid_o(sc_vld_b), .sin_o(sb), .cos_o(cb)
  );
  gcd_sincos u_sc_d (
    .clk_i, .rst_ni, .en_i(en), .valid_i(red_vld_q), .deg_i(dl_q),
    .valid_o(sc_vld_d), .sin_o(sd), .cos_o(cd)
  );

  logic signed [2*SC_W-1:0] pss_q, pcc_q, p3_q;
  logic signed [SC_W-1:0]   cd1_q, cd2_q, rss_q, rcc_q, rss3_q, c_q;
  logic signed [SC_W:0]     c_d;
  logic [3:0]               pr_vld_q;

  always_comb begin
    c_d = (SC_W + 1)'(rss3_q) + (SC_W + 1)'(rnd_s(64'(p3_q), ANGLE_FRAC_BITS));
    if (c_d > ((SC_W + 1)'(1) <<< ANGLE_FRAC_BITS)) begin
      c_d = (SC_W + 1)'(1) <<< ANGLE_FRAC_BITS;
    end else if (c_d < -((SC_W + 1)'(1) <<< ANGLE_FRAC_BITS)) begin
      c_d = -((SC_W + 1)'(1) <<< ANGLE_FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pss_q  <= (2 * SC_W)'(sa) * (2 * SC_W)'(sb);
      pcc_q  <= (2 * SC_W)'(ca) * (2 * SC_W)'(cb);
      cd1_q  <= cd;
      rss_q  <= SC_W'(rnd_s(64'(pss_q), ANGLE_FRAC_BITS));
      rcc_q  <= SC_W'(rnd_s(64'(pcc_q), ANGLE_FRAC_BITS));
      cd2_q  <= cd1_q;
      p3_q   <= (2 * SC_W)'(rcc_q) * (2 * SC_W)'(cd2_q);
      rss3_q <= rss_q;
      c_q    <= SC_W'(c_d);
    end
  end

  logic             ac_vld;
  logic [ANG_W-1:0] ang;

  gcd_acos u_acos (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pr_vld_q[3]), .c_i(c_q),
    .valid_o(ac_vld), .ang_o(ang)
  );

  localparam int unsigned ST_P_W   = ANG_W + 12;
  localparam int unsigned ST_SHIFT = ANGLE_FRAC_BITS - 8;
  localparam logic [ST_P_W-1:0] ST_HALF =
    (ST_SHIFT > 0) ? (ST_P_W'(1) << (ST_SHIFT - 1)) : '0;
  localparam int unsigned NM_P_W   = OUT_W + 24;

  logic [ST_P_W-1:0] stp_q, st_sum_d, st_sh_d;
  logic [OUT_W-1:0]  st_q, st_out_q, nm_out_q;
  logic [NM_P_W-1:0] nmp_q, nm_sum_d, nm_sh_d;
  logic [2:0]        ds_vld_q;

  always_comb begin
    st_sum_d = stp_q + ST_HALF;
    st_sh_d  = st_sum_d >> ST_SHIFT;
    nm_sum_d = nmp_q + (NM_P_W'(1) << 23);
    nm_sh_d  = nm_sum_d >> 24;
  end

  logic [OUT_W-1:0] st1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      stp_q    <= ST_P_W'(ang) * ST_P_W'(MILES_PER_RAD);
      st_q     <= (st_sh_d > ST_P_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(st_sh_d);
      nmp_q    <= NM_P_W'(st_q) * NM_P_W'(NM_FACTOR_Q24);
      st1_q    <= st_q;
      nm_out_q <= (nm_sh_d > NM_P_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(nm_sh_d);
      st_out_q <= st1_q;
    end
  end

  // Copies b and d run in lockstep with copy a; their valid bits track it.
  logic sc_vld_all;
  assign sc_vld_all = sc_vld & sc_vld_b & sc_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      red_vld_q <= 1'b0;
      pr_vld_q  <= '0;
      ds_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q  <= req_i.valid;
      red_vld_q <= in_vld_q;
      pr_vld_q  <= {pr_vld_q[2:0], sc_vld_all};
      ds_vld_q  <= {ds_vld_q[1:0], ac_vld};
      out_vld_q <= ds_vld_q[2];
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.dist_statute  = st_out_q;
  assign rsp_o.dist_nautical = nm_out_q;

endmodule

/* hw/rtl/gcd_sincos.sv */
// Pipelined sine and cosine of an angle in degrees by rotation CORDIC.
module gcd_sincos import gcd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [DEG_W-1:0] deg_i,
  output logic                    valid_o,
  output logic signed [SC_W-1:0]  sin_o,
  output logic signed [SC_W-1:0]  cos_o
);

  logic signed [DEG_W-1:0] fold_d;
  logic                    flip_d;
  logic                    neg_d;
  logic [MAG_W-1:0]        mag_q;
  logic                    neg_a_q, neg_b_q, neg_c_q;
  logic                    flip_a_q, flip_b_q, flip_c_q;
  logic [RAD_P_W-1:0]      rad_p_d;
  logic [RAD_T_W-1:0]      rad_t_q;
  logic [RAD_T_W+RCP_W-1:0] rcp_p_d;
  logic [Q_W-1:0]          q_q;
  logic signed [CW-1:0]    z0_d;
  logic [3:0]              pre_vld_q;
  logic [CORDIC_STAGES-1:0] vld_q;

  logic signed [CW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] z_q [CORDIC_STAGES+1];
  logic                 flip_q [CORDIC_STAGES+1];

  always_comb begin
    fold_d = deg_i;
    flip_d = 1'b0;
    if (deg_i > DEG_QUART) begin
      fold_d = DEG_HALF - deg_i;
      flip_d = 1'b1;
    end else if (deg_i < -DEG_QUART) begin
      fold_d = -DEG_HALF - deg_i;
      flip_d = 1'b1;
    end
    neg_d = fold_d < 0;
  end

  assign rad_p_d = RAD_P_W'(mag_q) * RAD_P_W'(PI_Q32) + RAD_HALF_DEN;
  assign rcp_p_d = (RAD_T_W + RCP_W)'(rad_t_q) * (RAD_T_W + RCP_W)'(RCP_M);
  assign z0_d    = (neg_c_q ? -CW'(q_q) : CW'(q_q)) <<< (WB - ANGLE_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q    <= MAG_W'(neg_d ? -fold_d : fold_d);
      neg_a_q  <= neg_d;
      flip_a_q <= flip_d;
      rad_t_q  <= rad_p_d[RAD_SHIFT +: RAD_T_W];
      neg_b_q  <= neg_a_q;
      flip_b_q <= flip_a_q;
      q_q      <= rcp_p_d[RCP_K +: Q_W];
      neg_c_q  <= neg_b_q;
      flip_c_q <= flip_b_q;
      x_q[0]   <= GAIN_Q30;
      y_q[0]   <= '0;
      z_q[0]   <= z0_d;
      flip_q[0] <= flip_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
      vld_q     <= '0;
    end else if (en_i) begin
      pre_vld_q <= {pre_vld_q[2:0], valid_i};
      vld_q     <= {vld_q[CORDIC_STAGES-2:0], pre_vld_q[3]};
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    localparam logic signed [CW-1:0] ATAN = CW'(atan_q30(i));
    logic signed [CW-1:0] x_d, y_d, z_d;
    always_comb begin
      if (z_q[i] >= 0) begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - ATAN;
      end else begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + ATAN;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  logic signed [SC_W-1:0] sin_d, cos_d, sin_q, cos_q;
  logic                   out_vld_q;

  always_comb begin
    sin_d = SC_W'(rnd_s(64'(y_q[CORDIC_STAGES]), WB - ANGLE_FRAC_BITS));
    cos_d = SC_W'(rnd_s(64'(x_q[CORDIC_STAGES]), WB - ANGLE_FRAC_BITS));
    if (flip_q[CORDIC_STAGES]) begin
      cos_d = -cos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[CORDIC_STAGES-1];
    end
  end

  assign valid_o = out_vld_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

/* hw/rtl/gcd_acos.sv */
// Pipelined arccosine: square root stages followed by vectoring CORDIC.
module gcd_acos import gcd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [SC_W-1:0] c_i,
  output logic                   valid_o,
  output logic [ANG_W-1:0]       ang_o
);

  logic [RM_W-1:0]        sq_d;
  logic [RM_W-1:0]        rem_q  [SQ_W+1];
  logic [RM_W-1:0]        root_q [SQ_W+1];
  logic signed [SC_W-1:0] cs_q   [SQ_W+1];
  logic [SQ_W:0]          sq_vld_q;

  assign sq_d = RM_W'(c_i * c_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= (RM_W'(1) << (2 * ANGLE_FRAC_BITS)) - sq_d;
      root_q[0] <= '0;
      cs_q[0]   <= c_i;
    end
  end

  for (genvar j = 0; j < SQ_W; j++) begin : g_sqrt
    localparam logic [RM_W-1:0] BIT = RM_W'(1) << (2 * (SQ_W - 1 - j));
    logic [RM_W-1:0] rem_d, root_d;
    always_comb begin
      if (rem_q[j] >= root_q[j] + BIT) begin
        rem_d  = rem_q[j] - (root_q[j] + BIT);
        root_d = (root_q[j] >> 1) + BIT;
      end else begin
        rem_d  = rem_q[j];
        root_d = root_q[j] >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= rem_d;
        root_q[j+1] <= root_d;
        cs_q[j+1]   <= cs_q[j];
      end
    end
  end

  logic signed [CW-1:0]   x_q [CORDIC_STAGES+1];
  logic signed [CW-1:0]   y_q [CORDIC_STAGES+1];
  logic signed [CW-1:0]   z_q [CORDIC_STAGES+1];
  logic                   cneg_q [CORDIC_STAGES+1];
  logic signed [SC_W-1:0] c_last;
  logic [CORDIC_STAGES:0] vec_vld_q;

  assign c_last = cs_q[SQ_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CW'(c_last < 0 ? -c_last : c_last) <<< (WB - ANGLE_FRAC_BITS);
      y_q[0]    <= CW'(root_q[SQ_W][SQ_W-1:0]) <<< (WB - ANGLE_FRAC_BITS);
      z_q[0]    <= '0;
      cneg_q[0] <= c_last < 0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    localparam logic signed [CW-1:0] ATAN = CW'(atan_q30(i));
    logic signed [CW-1:0] x_d, y_d, z_d;
    always_comb begin
      if (y_q[i] > 0) begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + ATAN;
      end else begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - ATAN;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        cneg_q[i+1] <= cneg_q[i];
      end
    end
  end

  logic signed [CW-1:0]  zadj_q;
  logic signed [63:0]    zr_d;
  logic [ANG_W-1:0]      ang_q;
  logic [1:0]            end_vld_q;

  assign zr_d = rnd_s(64'(zadj_q), WB - ANGLE_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zadj_q <= cneg_q[CORDIC_STAGES] ? PI_Q30 - z_q[CORDIC_STAGES] : z_q[CORDIC_STAGES];
      ang_q  <= (zr_d < 0) ? '0 : ANG_W'(zr_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q  <= '0;
      vec_vld_q <= '0;
      end_vld_q <= '0;
    end else if (en_i) begin
      sq_vld_q  <= {sq_vld_q[SQ_W-1:0], valid_i};
      vec_vld_q <= {vec_vld_q[CORDIC_STAGES-1:0], sq_vld_q[SQ_W]};
      end_vld_q <= {end_vld_q[0], vec_vld_q[CORDIC_STAGES]};
    end
  end

  assign valid_o = end_vld_q[1];
  assign ang_o   = ang_q;

endmodule

/* dv/great_circle_distance_test.sv */
// Testbench for the great-circle distance block: random and directed position pairs checked against a predictor.
`timescale 1ns / 100ps

module great_circle_distance_test;
  import gcd_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] statute;
    logic [OUT_W-1:0] nautical;
  } dist_t;

  class distance_scoreboard;
    dist_t pending[$];
    int unsigned errors;
    int unsigned checked;

    static function longint shr_floor(longint v, int unsigned s);
      return v >>> s;
    endfunction

    static function longint round_away(longint v, int unsigned s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (s - 1))) >>> s;
      return (v < 0) ? -m : m;
    endfunction

    static function longint arctan_entry(int unsigned i);
      longint t[32] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                        128, 64, 32, 16, 8, 4, 2, 1, 0};
      return t[i];
    endfunction

    static function void sine_cosine(longint d, output longint sn, output longint cs);
      longint full, half, quart, x, y, z, nx, ny, r;
      longint unsigned mag, den, q;
      bit flip, neg;
      full = 23592960;
      half = 11796480;
      quart = 5898240;
      flip = 0;
      d = d % full;
      if (d < 0) d += full;
      if (d >= half) d -= full;
      if (d > quart) begin
        d = half - d;
        flip = 1;
      end else if (d < -quart) begin
        d = -half - d;
        flip = 1;
      end
      neg = d < 0;
      mag = neg ? -d : d;
      den = 64'd180 << (48 - ANGLE_FRAC_BITS);
      q = (mag * 64'd13493037705 + den / 2) / den;
      r = neg ? -longint'(q) : longint'(q);
      x = 652032874;
      y = 0;
      z = r <<< (WB - ANGLE_FRAC_BITS);
      for (int unsigned i = 0; i < CORDIC_STAGES && i < 32; i++) begin
        if (z >= 0) begin
          nx = x - shr_floor(y, i);
          ny = y + shr_floor(x, i);
          z -= arctan_entry(i);
        end else begin
          nx = x + shr_floor(y, i);
          ny = y - shr_floor(x, i);
          z += arctan_entry(i);
        end
        x = nx;
        y = ny;
      end
      sn = round_away(y, WB - ANGLE_FRAC_BITS);
      cs = round_away(x, WB - ANGLE_FRAC_BITS);
      if (flip) cs = -cs;
    endfunction

    static function longint unsigned floor_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    static function longint central_angle(longint c);
      longint one, x, y, z, nx, ny;
      one = 64'sd1 <<< ANGLE_FRAC_BITS;
      z = 0;
      x = ((c < 0) ? -c : c) <<< (WB - ANGLE_FRAC_BITS);
      y = longint'(floor_root(one * one - c * c)) <<< (WB - ANGLE_FRAC_BITS);
      for (int unsigned i = 0; i < CORDIC_STAGES && i < 32; i++) begin
        if (y > 0) begin
          nx = x + shr_floor(y, i);
          ny = y - shr_floor(x, i);
          z += arctan_entry(i);
        end else begin
          nx = x - shr_floor(y, i);
          ny = y + shr_floor(x, i);
          z -= arctan_entry(i);
        end
        x = nx;
        y = ny;
      end
      if (c < 0) z = 64'sd3373259426 - z;
      z = round_away(z, WB - ANGLE_FRAC_BITS);
      return (z < 0) ? 0 : z;
    endfunction

    function void note_position_pair(logic signed [23:0] lat_a, logic signed [24:0] lon_a,
                                     logic signed [23:0] lat_b, logic signed [24:0] lon_b);
      longint sa, ca, sb, cb, sd, cd, c, one, ang;
      longint unsigned st, nm;
      dist_t e;
      sine_cosine(longint'(lat_a), sa, ca);
      sine_cosine(longint'(lat_b), sb, cb);
      sine_cosine(longint'(lon_b) - longint'(lon_a), sd, cd);
      c = round_away(sa * sb, ANGLE_FRAC_BITS) +
          round_away(round_away(ca * cb, ANGLE_FRAC_BITS) * cd, ANGLE_FRAC_BITS);
      one = 64'sd1 <<< ANGLE_FRAC_BITS;
      if (c > one) c = one;
      if (c < -one) c = -one;
      ang = central_angle(c);
      st = (longint'(ang) * 3963 + (64'd1 << (ANGLE_FRAC_BITS - 9))) >> (ANGLE_FRAC_BITS - 8);
      if (st > 4194303) st = 4194303;
      nm = (st * 64'd14578998 + (64'd1 << 23)) >> 24;
      if (nm > 4194303) nm = 4194303;
      e.statute = st[OUT_W-1:0];
      e.nautical = nm[OUT_W-1:0];
      pending.push_back(e);
    endfunction

    function void check_distance(logic [OUT_W-1:0] statute, logic [OUT_W-1:0] nautical);
      dist_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result statute %0d nautical %0d", $time, statute, nautical);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (statute !== e.statute) begin
        $display("%0t: statute expected %0d actual %0d", $time, e.statute, statute);
        errors++;
      end
      if (nautical !== e.nautical) begin
        $display("%0t: nautical expected %0d actual %0d", $time, e.nautical, nautical);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent = 0;

  gcd_in_if req();
  gcd_out_if rsp();

  great_circle_distance DUT (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  distance_scoreboard board = new();

  always #5 clk_i = ~clk_i;

  initial begin
    req.valid = 0;
    req.lat_a_deg = 0;
    req.lon_a_deg = 0;
    req.lat_b_deg = 0;
    req.lon_b_deg = 0;
    rsp.ready = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready)
        board.note_position_pair(req.lat_a_deg, req.lon_a_deg, req.lat_b_deg, req.lon_b_deg);
      if (rsp.valid && rsp.ready)
        board.check_distance(rsp.dist_statute, rsp.dist_nautical);
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_pair(logic signed [23:0] la, logic signed [24:0] ga,
                           logic signed [23:0] lb, logic signed [24:0] gb);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 0;
      @(posedge clk_i);
    end
    req.valid <= 1;
    req.lat_a_deg <= la;
    req.lon_a_deg <= ga;
    req.lat_b_deg <= lb;
    req.lon_b_deg <= gb;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic signed [23:0] any_lat();
    int unsigned m;
    m = $urandom_range(9);
    if (m == 0) return 24'($urandom);
    if (m == 1) return ($urandom_range(1)) ? 24'sd5898240 : -24'sd5898240;
    return 24'($signed($urandom_range(11796480)) - 5898240);
  endfunction

  function automatic logic signed [24:0] any_lon();
    int unsigned m;
    m = $urandom_range(9);
    if (m == 0) return 25'($urandom);
    if (m == 1) return ($urandom_range(1)) ? 25'sd11796480 : -25'sd11796480;
    return 25'($signed($urandom_range(23592960)) - 11796480);
  endfunction

  initial begin
    logic signed [23:0] la;
    logic signed [24:0] ga;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Same point, antipodes, poles, range edges and raw codes beyond range.
    send_pair(0, 0, 0, 0);
    send_pair(0, 0, 0, 25'sd11796480);
    send_pair(24'sd5898240, 0, -24'sd5898240, 0);
    send_pair(24'sd5898240, 25'sd11796480, 24'sd5898240, -25'sd11796480);
    send_pair(-24'sd5898240, -25'sd11796480, 24'sd5898240, 25'sd11796480);
    send_pair(24'sd2621440, 25'sd1310720, 24'sd2621440, 25'sd1310720);
    send_pair(24'sd2621440, 25'sd1310720, 24'sd2621441, 25'sd1310720);
    send_pair(24'h7fffff, 25'h0ffffff, 24'h800000, 25'h1000000);
    send_pair(24'h800000, 25'h1000000, 24'h7fffff, 25'h0ffffff);
    send_pair(24'hffffff, 25'h1ffffff, 24'h000001, 25'h0000001);
    send_pair(24'h555555, 25'h0aaaaaa, 24'haaaaaa, 25'h1555555);
    send_pair(24'sd2650000, -25'sd7700000, -24'sd2200000, 25'sd9900000);
    send_pair(0, -25'sd11796480, 0, 25'sd11796479);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1 || p == 3) ? ((p == 3) ? 16 : 46) : 0;
      recv_stall_pct = (p == 2) ? 46 : ((p == 3) ? 16 : 0);
      for (int k = 0; k < 400; k++) begin
        la = any_lat();
        ga = any_lon();
        if ($urandom_range(7) == 0) send_pair(la, ga, la, ga + 25'($urandom_range(3)));
        else send_pair(la, ga, any_lat(), any_lon());
      end
    end
    req.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d position pairs, checked %0d distances, under four idle patterns.",
             sent, board.checked);
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", board.pending.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* great_circle_distance.f */
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_in_if.sv
hw/rtl/gcd_out_if.sv
hw/rtl/gcd_sincos.sv
hw/rtl/gcd_acos.sv
hw/rtl/great_circle_distance.sv
dv/great_circle_distance_test.sv
